FILE: hdl/cltrt_pkg.sv
// ----------------------------------------------------------------------------
// cltrt_pkg
// Shared types and codes of the log term run table.
// ----------------------------------------------------------------------------
package cltrt_pkg;

    typedef enum logic [2:0] {
        CMD_START    = 3'd0,
        CMD_APPEND   = 3'd1,
        CMD_TRUNCATE = 3'd2,
        CMD_TERM_OF  = 3'd3,
        CMD_SNAPSHOT = 3'd4,
        CMD_RESTORE  = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_START,
        DP_APPEND,
        DP_FULL,
        DP_INVALID,
        DP_RESTORE,
        DP_TERM_OUT,
        DP_WALK_X,
        DP_WALK_P,
        DP_STEP,
        DP_FOUND,
        DP_SNAP,
        DP_CUT,
        DP_DROP_I,
        DP_DROP_I1,
        DP_SUMMARY
    } dp_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RD,
        S_CMP,
        S_SNAP_MID,
        S_FIN,
        S_RESP
    } state_t;

    typedef enum logic [1:0] {
        W_FIND,
        W_FIND_SNAP,
        W_CUT,
        W_DROP
    } walk_t;

    typedef struct packed {
        cmd_t cmd;
        logic start_ok;
        logic app_invalid;
        logic app_full;
        logic in_range;
        logic x_zero;
        logic snap_ok;
        logic restore_ok;
        logic trim_ok;
        logic li_ge_key;
        logic li_eq_key;
        logic last_run;
    } dp_stat_t;

endpackage

FILE: hdl/cltrt_dp.sv
// ----------------------------------------------------------------------------
// cltrt_dp
// Datapath: run ring memories, log state registers and result registers.
// ----------------------------------------------------------------------------
module cltrt_dp #(
    parameter int RUN_SLOTS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cltrt_pkg::dp_op_t     op,
    output cltrt_pkg::dp_stat_t   stat,
    input  logic [2:0]            in_cmd,
    input  logic [63:0]           in_index,
    input  logic [63:0]           in_term,
    input  logic [63:0]           in_first_idx,
    input  logic [31:0]           trailing,
    output logic [1:0]            status,
    output logic [63:0]           found_term,
    output logic                  has_entry,
    output logic [63:0]           sum_last_idx,
    output logic [63:0]           sum_last_trm,
    output logic [63:0]           entry_count,
    output logic [63:0]           snap_index,
    output logic [63:0]           snap_term
);

    localparam int SW  = (RUN_SLOTS > 1) ? $clog2(RUN_SLOTS) : 1;
    localparam int CW  = $clog2(RUN_SLOTS + 1);
    localparam int CW1 = CW + 1;
    localparam logic [CW:0]   NSLOT_W = CW1'(RUN_SLOTS);
    localparam logic [CW-1:0] NSLOT_C = CW'(RUN_SLOTS);

    logic [63:0] li_mem   [RUN_SLOTS];
    logic [63:0] term_mem [RUN_SLOTS];

    cltrt_pkg::cmd_t cmd_reg;
    logic [63:0] x_reg, t_reg, si_reg, key_reg;
    logic [63:0] rd_li_reg, rd_term_reg, prev_li_reg, prev_term_reg;
    logic [63:0] tail_li_reg, tail_term_reg;
    logic [63:0] offset_reg, snap_idx_reg, snap_term_reg;
    logic [63:0] found_reg, out_li_reg, out_lt_reg, out_cnt_reg;
    logic [SW-1:0] front_reg;
    logic [CW-1:0] count_reg, i_reg;
    cltrt_pkg::status_t status_reg;
    logic has_reg;

    function automatic logic [SW-1:0] slot_of(input logic [SW-1:0] f,
                                             input logic [CW-1:0] n);
        logic [CW:0] s;
        s = CW1'(f) + CW1'(n);
        if (s >= NSLOT_W) begin
            s = s - NSLOT_W;
        end
        return s[SW-1:0];
    endfunction

    logic          n_nz, fresh, cut_clear, cut_prev;
    logic [63:0]   n_val, base, xm1, p_val, trail64;
    logic [SW-1:0] rd_addr, tail_slot, new_slot;
    logic [CW-1:0] i_inc;
    logic          we_li, we_term;
    logic [SW-1:0] wa;
    logic [63:0]   wli;

    always_comb begin
        trail64   = {32'd0, trailing};
        n_nz      = (count_reg != '0) && (tail_li_reg > offset_reg);
        n_val     = tail_li_reg - offset_reg;
        base      = (count_reg != '0) ? tail_li_reg : offset_reg;
        fresh     = (count_reg == '0) || (t_reg != tail_term_reg);
        xm1       = key_reg - 64'd1;
        p_val     = x_reg - trail64;
        i_inc     = i_reg + CW'(1);
        rd_addr   = slot_of(front_reg, i_reg);
        tail_slot = slot_of(front_reg, count_reg - CW'(1));
        new_slot  = slot_of(front_reg, count_reg);
        cut_clear = (i_reg == '0) && (xm1 == offset_reg);
        cut_prev  = (i_reg != '0) && (prev_li_reg == xm1);

        stat.cmd         = cmd_reg;
        stat.app_invalid = (t_reg == '0) || ((count_reg != '0) && (t_reg < tail_term_reg))
                           || (base == '1);
        stat.app_full    = fresh && (count_reg == NSLOT_C);
        stat.in_range    = (count_reg != '0) && (x_reg > offset_reg)
                           && (x_reg <= tail_li_reg);
        stat.start_ok    = !n_nz && (si_reg != '0) && ((si_reg - 64'd1) <= x_reg)
                           && !((x_reg != '0) && (t_reg == '0));
        stat.x_zero      = (x_reg == '0);
        stat.snap_ok     = (x_reg != '0) && (x_reg != snap_idx_reg) && stat.in_range;
        stat.restore_ok  = (x_reg != '0) && (t_reg != '0);
        stat.trim_ok     = (x_reg > trail64) && (p_val > offset_reg);
        stat.li_ge_key   = (rd_li_reg >= key_reg);
        stat.li_eq_key   = (rd_li_reg == key_reg);
        stat.last_run    = (i_inc == count_reg);

        we_li   = 1'b0;
        we_term = 1'b0;
        wa      = rd_addr;
        wli     = xm1;
        case (op)
            cltrt_pkg::DP_APPEND: begin
                we_li   = 1'b1;
                we_term = fresh;
                wa      = fresh ? new_slot : tail_slot;
                wli     = base + 64'd1;
            end
            cltrt_pkg::DP_CUT: begin
                we_li = !cut_clear && !cut_prev;
            end
            default: ;
        endcase
    end

    // ring memories, registered read
    always_ff @(posedge aclk) begin
        if (we_li) begin
            li_mem[wa] <= wli;
        end
        if (we_term) begin
            term_mem[wa] <= t_reg;
        end
        rd_li_reg   <= li_mem[rd_addr];
        rd_term_reg <= term_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg     <= '0;
            count_reg     <= '0;
            offset_reg    <= '0;
            snap_idx_reg  <= '0;
            snap_term_reg <= '0;
        end else begin
            case (op)
                cltrt_pkg::DP_START: begin
                    snap_idx_reg  <= x_reg;
                    snap_term_reg <= t_reg;
                    offset_reg    <= si_reg - 64'd1;
                end
                cltrt_pkg::DP_APPEND: begin
                    if (fresh) begin
                        count_reg <= count_reg + CW'(1);
                    end
                end
                cltrt_pkg::DP_RESTORE: begin
                    if (n_nz) begin
                        count_reg <= '0;
                        front_reg <= '0;
                    end
                    snap_idx_reg  <= x_reg;
                    snap_term_reg <= t_reg;
                    offset_reg    <= x_reg;
                end
                cltrt_pkg::DP_SNAP: begin
                    snap_idx_reg  <= x_reg;
                    snap_term_reg <= rd_term_reg;
                end
                cltrt_pkg::DP_CUT: begin
                    if (cut_clear) begin
                        count_reg <= '0;
                        front_reg <= '0;
                    end else if (cut_prev) begin
                        count_reg <= i_reg;
                    end else begin
                        count_reg <= i_inc;
                    end
                end
                cltrt_pkg::DP_DROP_I: begin
                    front_reg  <= slot_of(front_reg, i_reg);
                    count_reg  <= count_reg - i_reg;
                    offset_reg <= key_reg;
                end
                cltrt_pkg::DP_DROP_I1: begin
                    front_reg  <= slot_of(front_reg, i_inc);
                    count_reg  <= count_reg - i_inc;
                    offset_reg <= key_reg;
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        case (op)
            cltrt_pkg::DP_LOAD: begin
                cmd_reg    <= cltrt_pkg::cmd_t'(in_cmd);
                x_reg      <= in_index;
                t_reg      <= in_term;
                si_reg     <= in_first_idx;
                status_reg <= cltrt_pkg::ST_OK;
                found_reg  <= '0;
                has_reg    <= 1'b0;
            end
            cltrt_pkg::DP_APPEND: begin
                tail_li_reg <= base + 64'd1;
                if (fresh) begin
                    tail_term_reg <= t_reg;
                end
            end
            cltrt_pkg::DP_FULL:     status_reg <= cltrt_pkg::ST_FULL;
            cltrt_pkg::DP_INVALID:  status_reg <= cltrt_pkg::ST_INVALID;
            cltrt_pkg::DP_TERM_OUT: found_reg  <= (x_reg == snap_idx_reg) ? snap_term_reg : '0;
            cltrt_pkg::DP_WALK_X: begin
                i_reg   <= '0;
                key_reg <= x_reg;
            end
            cltrt_pkg::DP_WALK_P: begin
                i_reg   <= '0;
                key_reg <= p_val;
            end
            cltrt_pkg::DP_STEP: begin
                prev_li_reg   <= rd_li_reg;
                prev_term_reg <= rd_term_reg;
                i_reg         <= i_inc;
            end
            cltrt_pkg::DP_FOUND: begin
                found_reg <= rd_term_reg;
                has_reg   <= 1'b1;
            end
            cltrt_pkg::DP_CUT: begin
                if (cut_prev) begin
                    tail_li_reg   <= prev_li_reg;
                    tail_term_reg <= prev_term_reg;
                end else if (!cut_clear) begin
                    tail_li_reg   <= xm1;
                    tail_term_reg <= rd_term_reg;
                end
            end
            cltrt_pkg::DP_SUMMARY: begin
                out_cnt_reg <= n_nz ? n_val : '0;
                out_li_reg  <= n_nz ? tail_li_reg : snap_idx_reg;
                out_lt_reg  <= n_nz ? tail_term_reg
                             : ((snap_idx_reg != '0) ? snap_term_reg : '0);
            end
            default: ;
        endcase
    end

    assign status       = status_reg;
    assign found_term   = found_reg;
    assign has_entry    = has_reg;
    assign sum_last_idx = out_li_reg;
    assign sum_last_trm = out_lt_reg;
    assign entry_count  = out_cnt_reg;
    assign snap_index   = snap_idx_reg;
    assign snap_term    = snap_term_reg;

endmodule

FILE: hdl/cltrt_ctrl.sv
// ----------------------------------------------------------------------------
// cltrt_ctrl
// Controller: decodes a command and sequences ring walks in the datapath.
// ----------------------------------------------------------------------------
module cltrt_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  cltrt_pkg::dp_stat_t stat,
    output cltrt_pkg::dp_op_t   op
);

    cltrt_pkg::state_t state_reg, state_next;
    cltrt_pkg::walk_t  mode_reg, mode_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cltrt_pkg::S_IDLE;
            mode_reg  <= cltrt_pkg::W_FIND;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        mode_next  = mode_reg;
        op         = cltrt_pkg::DP_NOP;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            cltrt_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op         = cltrt_pkg::DP_LOAD;
                    state_next = cltrt_pkg::S_DECODE;
                end
            end
            cltrt_pkg::S_DECODE: begin
                state_next = cltrt_pkg::S_FIN;
                unique case (stat.cmd)
                    cltrt_pkg::CMD_START: begin
                        op = stat.start_ok ? cltrt_pkg::DP_START : cltrt_pkg::DP_INVALID;
                    end
                    cltrt_pkg::CMD_APPEND: begin
                        if (stat.app_invalid) begin
                            op = cltrt_pkg::DP_INVALID;
                        end else if (stat.app_full) begin
                            op = cltrt_pkg::DP_FULL;
                        end else begin
                            op = cltrt_pkg::DP_APPEND;
                        end
                    end
                    cltrt_pkg::CMD_TRUNCATE: begin
                        if (stat.in_range) begin
                            op         = cltrt_pkg::DP_WALK_X;
                            mode_next  = cltrt_pkg::W_CUT;
                            state_next = cltrt_pkg::S_RD;
                        end else begin
                            op = cltrt_pkg::DP_INVALID;
                        end
                    end
                    cltrt_pkg::CMD_TERM_OF: begin
                        if (stat.x_zero) begin
                            op = cltrt_pkg::DP_INVALID;
                        end else if (stat.in_range) begin
                            op         = cltrt_pkg::DP_WALK_X;
                            mode_next  = cltrt_pkg::W_FIND;
                            state_next = cltrt_pkg::S_RD;
                        end else begin
                            op = cltrt_pkg::DP_TERM_OUT;
                        end
                    end
                    cltrt_pkg::CMD_SNAPSHOT: begin
                        if (stat.snap_ok) begin
                            op         = cltrt_pkg::DP_WALK_X;
                            mode_next  = cltrt_pkg::W_FIND_SNAP;
                            state_next = cltrt_pkg::S_RD;
                        end else begin
                            op = cltrt_pkg::DP_INVALID;
                        end
                    end
                    cltrt_pkg::CMD_RESTORE: begin
                        op = stat.restore_ok ? cltrt_pkg::DP_RESTORE : cltrt_pkg::DP_INVALID;
                    end
                    default: op = cltrt_pkg::DP_INVALID;
                endcase
            end
            cltrt_pkg::S_RD: begin
                // wait for the registered ring read
                state_next = cltrt_pkg::S_CMP;
            end
            cltrt_pkg::S_CMP: begin
                state_next = cltrt_pkg::S_FIN;
                unique case (mode_reg) inside
                    cltrt_pkg::W_FIND, cltrt_pkg::W_FIND_SNAP: begin
                        if (stat.li_ge_key) begin
                            if (mode_reg == cltrt_pkg::W_FIND) begin
                                op = cltrt_pkg::DP_FOUND;
                            end else begin
                                op         = cltrt_pkg::DP_SNAP;
                                state_next = cltrt_pkg::S_SNAP_MID;
                            end
                        end else if (!stat.last_run) begin
                            op         = cltrt_pkg::DP_STEP;
                            state_next = cltrt_pkg::S_RD;
                        end
                    end
                    cltrt_pkg::W_CUT: begin
                        if (!stat.last_run && !stat.li_ge_key) begin
                            op         = cltrt_pkg::DP_STEP;
                            state_next = cltrt_pkg::S_RD;
                        end else begin
                            op = cltrt_pkg::DP_CUT;
                        end
                    end
                    cltrt_pkg::W_DROP: begin
                        if (stat.li_ge_key && !stat.li_eq_key) begin
                            op = cltrt_pkg::DP_DROP_I;
                        end else if (stat.li_eq_key || stat.last_run) begin
                            op = cltrt_pkg::DP_DROP_I1;
                        end else begin
                            op         = cltrt_pkg::DP_STEP;
                            state_next = cltrt_pkg::S_RD;
                        end
                    end
                    default: ;
                endcase
            end
            cltrt_pkg::S_SNAP_MID: begin
                if (stat.trim_ok) begin
                    op         = cltrt_pkg::DP_WALK_P;
                    mode_next  = cltrt_pkg::W_DROP;
                    state_next = cltrt_pkg::S_RD;
                end else begin
                    state_next = cltrt_pkg::S_FIN;
                end
            end
            cltrt_pkg::S_FIN: begin
                op         = cltrt_pkg::DP_SUMMARY;
                state_next = cltrt_pkg::S_RESP;
            end
            cltrt_pkg::S_RESP: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = cltrt_pkg::S_IDLE;
                end
            end
            default: state_next = cltrt_pkg::S_IDLE;
        endcase
    end

endmodule

FILE: hdl/consensus_log_term_run_table_top.sv
// ----------------------------------------------------------------------------
// consensus_log_term_run_table_top
// Term history of a replicated log kept as a fixed ring of runs.
// ----------------------------------------------------------------------------
// Input channel s_*: one command word (cmd, index, term, start_index) per
// valid/ready handshake. Result channel m_*: one result word per command,
// carrying status, looked-up term, has-entry flag and the log summary.
// One command is in flight at a time: s_ready is high only while idle.
// Sequence: start, append, restore and rejected commands go from decode to
// the summary state and then raise m_valid. Truncate and term lookup walk
// the ring with one memory read and one compare per run, over at most
// RUN_SLOTS runs. Snapshot is one lookup walk plus an optional prefix-drop
// walk. s_ready returns in the cycle after the result word is taken.
// The result is held on m_* until m_ready; no new word is taken meanwhile.
// Reset (aresetn low, synchronous) empties the ring and clears the offset,
// snapshot index/term and the trailing register; no clearing pass is run.
// snapshot_trailing is written through the APB port at address 0 (decoded from paddr[2] alone);
// the user must write it only while the block is idle, which the block does not enforce.
module consensus_log_term_run_table_top #(
    parameter int RUN_SLOTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_cmd,
    input  logic [63:0] s_index,
    input  logic [63:0] s_term,
    input  logic [63:0] s_start_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [63:0] m_found_term,
    output logic        m_has_entry,
    output logic [63:0] m_last_index,
    output logic [63:0] m_last_term,
    output logic [63:0] m_entry_count,
    output logic [63:0] m_snap_index,
    output logic [63:0] m_snap_term,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0] trailing_reg;
    cltrt_pkg::dp_op_t   op;
    cltrt_pkg::dp_stat_t stat;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? trailing_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trailing_reg <= '0;
        end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
            trailing_reg <= pwdata;
        end
    end

    cltrt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .op      (op)
    );

    cltrt_dp #(
        .RUN_SLOTS (RUN_SLOTS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .op             (op),
        .stat           (stat),
        .in_cmd         (s_cmd),
        .in_index       (s_index),
        .in_term        (s_term),
        .in_first_idx   (s_start_index),
        .trailing       (trailing_reg),
        .status         (m_status),
        .found_term     (m_found_term),
        .has_entry      (m_has_entry),
        .sum_last_idx   (m_last_index),
        .sum_last_trm   (m_last_term),
        .entry_count    (m_entry_count),
        .snap_index     (m_snap_index),
        .snap_term      (m_snap_term)
    );

endmodule

FILE: hdl/cltrt_checker.sv
// ----------------------------------------------------------------------------
// cltrt_checker
// Port-level checks of the log term run table, bound to the top level.
// ----------------------------------------------------------------------------
module cltrt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic [63:0] m_found_term,
    input logic        m_has_entry,
    input logic [63:0] m_entry_count
);

    // one command in flight: never take a word while a result is shown
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while result pending");

    // a rejected or full command reports no lookup
    a_no_lookup_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != cltrt_pkg::ST_OK) |-> (m_found_term == '0 && !m_has_entry))
        else $error("lookup reported on failed command");

    // an index found within the entries implies a non-empty log
    a_has_entry_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_has_entry) |-> (m_entry_count != '0))
        else $error("entry found in empty log");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_status) && $stable(m_found_term)))
        else $error("result changed under stall");

endmodule

bind consensus_log_term_run_table_top cltrt_checker u_cltrt_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_found_term  (m_found_term),
    .m_has_entry   (m_has_entry),
    .m_entry_count (m_entry_count)
);

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the log term run table.
// A short directed table runs first, then random command words in several
// phases, each with its own trailing window written over APB while idle.
// Every result word is checked against a local model of the run ring.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int RUN_SLOTS = 16;
    localparam logic [2:0] CMD_UNDEF_A = 3'd6;
    localparam logic [2:0] CMD_UNDEF_B = 3'd7;
    localparam logic [2:0] REG_SNAP_TRAILING = 3'd0;
    localparam logic [63:0] IDX_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int PHASE_WORDS = 390;

    typedef struct {
        cltrt_pkg::status_t status;
        logic [63:0] found_term;
        logic        has_entry;
        logic [63:0] end_index;
        logic [63:0] end_term;
        logic [63:0] entry_count;
        logic [63:0] snap_index;
        logic [63:0] snap_term;
    } summary_t;

    typedef struct {
        logic [2:0]  cmd;
        logic [63:0] idx;
        logic [63:0] trm;
        logic [63:0] sidx;
        bit          typed;
        cltrt_pkg::status_t st;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_cmd = '0;
    logic [63:0] s_index = '0;
    logic [63:0] s_term = '0;
    logic [63:0] s_start_index = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [63:0] m_found_term;
    logic        m_has_entry;
    logic [63:0] m_last_index;
    logic [63:0] m_last_term;
    logic [63:0] m_entry_count;
    logic [63:0] m_snap_index;
    logic [63:0] m_snap_term;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    consensus_log_term_run_table_top #(.RUN_SLOTS(RUN_SLOTS)) u_top (.*);

    always #5 aclk = ~aclk;

    // local copy of the run ring
    logic [63:0] run_li [RUN_SLOTS];
    logic [63:0] run_tm [RUN_SLOTS];
    int          ring_front;
    int          run_count;
    logic [63:0] log_offset;
    logic [63:0] snap_idx;
    logic [63:0] snap_tm;
    logic [63:0] trailing;

    summary_t pending_results[$];
    int       mismatches = 0;

    function automatic int slot(int i);
        return (ring_front + i) % RUN_SLOTS;
    endfunction

    function automatic logic [63:0] entries_held();
        logic [63:0] li;
        if (run_count == 0) return 64'd0;
        li = run_li[slot(run_count - 1)];
        return (li > log_offset) ? li - log_offset : 64'd0;
    endfunction

    function automatic logic [63:0] log_last_index();
        logic [63:0] n;
        n = entries_held();
        return (n == 0) ? snap_idx : log_offset + n;
    endfunction

    function automatic logic [63:0] term_of_index(logic [63:0] x);
        if (x <= log_offset || x - log_offset > entries_held())
            return (x == snap_idx) ? snap_tm : 64'd0;
        for (int i = 0; i < run_count; i++)
            if (run_li[slot(i)] >= x) return run_tm[slot(i)];
        return 64'd0;
    endfunction

    function automatic bit index_held(logic [63:0] x);
        if (run_count == 0 || x <= log_offset) return 1'b0;
        return x <= run_li[slot(run_count - 1)];
    endfunction

    function automatic void cut_log(logic [63:0] x);
        int k;
        k = 0;
        while (k + 1 < run_count && run_li[slot(k)] < x) k++;
        if (k == 0 && x - 1 == log_offset) begin
            run_count = 0;
            ring_front = 0;
        end else if (k > 0 && run_li[slot(k - 1)] == x - 1) begin
            run_count = k;
        end else begin
            run_li[slot(k)] = x - 1;
            run_count = k + 1;
        end
    endfunction

    function automatic void drop_runs_upto(logic [63:0] p);
        int dropped;
        logic [63:0] li;
        dropped = 0;
        while (dropped < run_count) begin
            li = run_li[slot(dropped)];
            if (li > p) break;
            dropped++;
            if (li == p) break;
        end
        ring_front = (ring_front + dropped) % RUN_SLOTS;
        run_count -= dropped;
        log_offset = p;
    endfunction

    function automatic cltrt_pkg::status_t append_term(logic [63:0] t);
        logic [63:0] base;
        bit fresh;
        if (t == 0) return cltrt_pkg::ST_INVALID;
        if (run_count > 0) begin
            if (t < run_tm[slot(run_count - 1)]) return cltrt_pkg::ST_INVALID;
            base = run_li[slot(run_count - 1)];
            fresh = (t != run_tm[slot(run_count - 1)]);
        end else begin
            base = log_offset;
            fresh = 1'b1;
        end
        if (base == IDX_MAX) return cltrt_pkg::ST_INVALID;
        if (!fresh) begin
            run_li[slot(run_count - 1)] = base + 1;
            return cltrt_pkg::ST_OK;
        end
        if (run_count >= RUN_SLOTS) return cltrt_pkg::ST_FULL;
        run_li[slot(run_count)] = base + 1;
        run_tm[slot(run_count)] = t;
        run_count++;
        return cltrt_pkg::ST_OK;
    endfunction

    function automatic summary_t apply_command(logic [2:0] cmd, logic [63:0] x,
                                               logic [63:0] t, logic [63:0] si);
        summary_t r;
        logic [63:0] lt;
        r.status = cltrt_pkg::ST_OK;
        r.found_term = '0;
        r.has_entry = 1'b0;
        case (cmd)
            cltrt_pkg::CMD_START: begin
                if (entries_held() != 0 || si == 0 || si - 1 > x || (x != 0 && t == 0)) begin
                    r.status = cltrt_pkg::ST_INVALID;
                end else begin
                    snap_idx = x;
                    snap_tm = t;
                    log_offset = si - 1;
                end
            end
            cltrt_pkg::CMD_APPEND: r.status = append_term(t);
            cltrt_pkg::CMD_TRUNCATE: begin
                if (run_count == 0 || x <= log_offset || x > run_li[slot(run_count - 1)])
                    r.status = cltrt_pkg::ST_INVALID;
                else
                    cut_log(x);
            end
            cltrt_pkg::CMD_TERM_OF: begin
                if (x == 0) begin
                    r.status = cltrt_pkg::ST_INVALID;
                end else begin
                    r.found_term = term_of_index(x);
                    r.has_entry = index_held(x);
                end
            end
            cltrt_pkg::CMD_SNAPSHOT: begin
                lt = (x == 0 || x == snap_idx) ? 64'd0 : term_of_index(x);
                if (lt == 0) begin
                    r.status = cltrt_pkg::ST_INVALID;
                end else begin
                    snap_idx = x;
                    snap_tm = lt;
                    if (x > trailing && term_of_index(x - trailing) != 0)
                        drop_runs_upto(x - trailing);
                end
            end
            cltrt_pkg::CMD_RESTORE: begin
                if (x == 0 || t == 0) begin
                    r.status = cltrt_pkg::ST_INVALID;
                end else begin
                    if (entries_held() > 0) begin
                        run_count = 0;
                        ring_front = 0;
                    end
                    snap_idx = x;
                    snap_tm = t;
                    log_offset = x;
                end
            end
            default: r.status = cltrt_pkg::ST_INVALID;
        endcase
        r.end_index = log_last_index();
        r.end_term = (r.end_index > 0) ? term_of_index(r.end_index) : 64'd0;
        r.entry_count = entries_held();
        r.snap_index = snap_idx;
        r.snap_term = snap_tm;
        return r;
    endfunction

    // sender pacing
    int burst_left = 0;

    task automatic send_word(logic [2:0] cmd, logic [63:0] x, logic [63:0] t,
                             logic [63:0] si, bit typed, cltrt_pkg::status_t st);
        summary_t r;
        r = apply_command(cmd, x, t, si);
        if (typed) r.status = st;
        pending_results.push_back(r);
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_index <= x;
        s_term <= t;
        s_start_index <= si;
        do @(posedge aclk); while (!s_ready);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 2) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        // idle a while before the next phase
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_trailing(logic [31:0] v);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= REG_SNAP_TRAILING;
        pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        trailing = {32'd0, v};
        @(posedge aclk);
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // receiver stall pattern: m_ready is random, with a stall rate redrawn from 0, 30, 70 and 95 percent
    int stall_pct = 0;
    int stall_tick = 0;
    always @(posedge aclk) begin
        stall_tick <= stall_tick + 1;
        if (stall_tick % 64 == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pct <= 0;
                1: stall_pct <= 30;
                2: stall_pct <= 70;
                default: stall_pct <= 95;
            endcase
        end
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // result checker
    always @(posedge aclk) begin
        summary_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word");
            end else begin
                e = pending_results.pop_front();
                if (m_status !== e.status || m_found_term !== e.found_term ||
                    m_has_entry !== e.has_entry || m_last_index !== e.end_index ||
                    m_last_term !== e.end_term || m_entry_count !== e.entry_count ||
                    m_snap_index !== e.snap_index || m_snap_term !== e.snap_term) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch exp st=%0d ft=%h he=%0d li=%h lt=%h n=%h si=%h stm=%h",
                            e.status, e.found_term, e.has_entry, e.end_index,
                            e.end_term, e.entry_count, e.snap_index, e.snap_term);
                        $display("         got st=%0d ft=%h he=%0d li=%h lt=%h n=%h si=%h stm=%h",
                            m_status, m_found_term, m_has_entry, m_last_index,
                            m_last_term, m_entry_count, m_snap_index, m_snap_term);
                    end
                end
            end
        end
    end

    // random command word shaped on the current log
    task automatic send_random();
        logic [63:0] li, lo, x, t, si, top_term;
        logic [2:0] cmd;
        int r;
        li = log_last_index();
        lo = log_offset;
        top_term = (run_count > 0) ? run_tm[slot(run_count - 1)] : snap_tm;
        x = li;
        t = top_term;
        si = '0;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            cmd = cltrt_pkg::CMD_APPEND;
            case ($urandom_range(0, 19))
                0: t = 64'd0;
                1: t = (top_term > 0) ? top_term - 1 : 64'd0;
                2: t = rnd64();
                default: t = top_term + (($urandom_range(0, 9) < 4) ? $urandom_range(1, 3) : 0);
            endcase
            if (t == 0 && $urandom_range(0, 1)) t = 64'd1;
        end else if (r < 55) begin
            cmd = cltrt_pkg::CMD_TERM_OF;
            x = lo + $urandom_range(0, 40) - 2;
        end else if (r < 65) begin
            cmd = cltrt_pkg::CMD_TRUNCATE;
            x = lo + $urandom_range(0, (li > lo) ? int'(li - lo) + 1 : 2);
        end else if (r < 75) begin
            cmd = cltrt_pkg::CMD_SNAPSHOT;
            x = lo + $urandom_range(0, (li > lo) ? int'(li - lo) + 1 : 2);
        end else if (r < 80) begin
            cmd = cltrt_pkg::CMD_RESTORE;
            x = ($urandom_range(0, 3) == 0) ? IDX_MAX - $urandom_range(0, 3)
                                           : 64'($urandom_range(0, 500));
            t = ($urandom_range(0, 9) == 0) ? 64'd0 : 64'($urandom_range(1, 50));
        end else if (r < 86) begin
            cmd = cltrt_pkg::CMD_START;
            x = ($urandom_range(0, 4) == 0) ? rnd64() : 64'($urandom_range(0, 300));
            t = ($urandom_range(0, 7) == 0) ? 64'd0 : 64'($urandom_range(1, 40));
            si = ($urandom_range(0, 4) == 0) ? rnd64() : x + 1 - $urandom_range(0, 5);
            if (run_count > 0 && $urandom_range(0, 1)) begin
                // empty the log first so start can take
                send_word(cltrt_pkg::CMD_TRUNCATE, lo + 1, '0, '0, 1'b0, cltrt_pkg::ST_OK);
            end
        end else if (r < 92) begin
            cmd = $urandom_range(0, 1) ? CMD_UNDEF_A : CMD_UNDEF_B;
            x = rnd64();
            t = rnd64();
            si = rnd64();
        end else begin
            cmd = 3'($urandom_range(0, 5));
            x = rnd64();
            t = rnd64();
            si = rnd64();
        end
        send_word(cmd, x, t, si, 1'b0, cltrt_pkg::ST_OK);
    endtask

    row_t directed_rows[22] = '{
        '{cltrt_pkg::CMD_TERM_OF,  64'd0,   64'd0,   64'd0,  1'b1, cltrt_pkg::ST_INVALID},
        '{cltrt_pkg::CMD_APPEND,   64'd0,   64'd0,   64'd0,  1'b1, cltrt_pkg::ST_INVALID},
        '{cltrt_pkg::CMD_TRUNCATE, 64'd5,   64'd0,   64'd0,  1'b1, cltrt_pkg::ST_INVALID},
        '{cltrt_pkg::CMD_SNAPSHOT, 64'd0,   64'd0,   64'd0,  1'b1, cltrt_pkg::ST_INVALID},
        '{cltrt_pkg::CMD_RESTORE,  64'd0,   64'd3,   64'd0,  1'b1, cltrt_pkg::ST_INVALID},
        '{CMD_UNDEF_A,             IDX_MAX, IDX_MAX, IDX_MAX, 1'b1, cltrt_pkg::ST_INVALID},
        '{CMD_UNDEF_B,             64'd0,   64'd0,   64'd0,  1'b1, cltrt_pkg::ST_INVALID},
        '{cltrt_pkg::CMD_START,    64'd5,   64'd2,   64'd0,  1'b1, cltrt_pkg::ST_INVALID},
        '{cltrt_pkg::CMD_START,    64'd5,   64'd0,   64'd6,  1'b1, cltrt_pkg::ST_INVALID},
        '{cltrt_pkg::CMD_START,    64'd5,   64'd2,   64'd8,  1'b1, cltrt_pkg::ST_INVALID},
        '{cltrt_pkg::CMD_START,    64'd10,  64'd2,   64'd11, 1'b1, cltrt_pkg::ST_OK},
        '{cltrt_pkg::CMD_APPEND,   64'd0,   64'd2,   64'd0,  1'b0, cltrt_pkg::ST_OK},
        '{cltrt_pkg::CMD_APPEND,   64'd0,   64'd2,   64'd0,  1'b0, cltrt_pkg::ST_OK},
        '{cltrt_pkg::CMD_APPEND,   64'd0,   64'd3,   64'd0,  1'b0, cltrt_pkg::ST_OK},
        '{cltrt_pkg::CMD_APPEND,   64'd0,   64'd1,   64'd0,  1'b1, cltrt_pkg::ST_INVALID},
        '{cltrt_pkg::CMD_TERM_OF,  64'd11,  64'd0,   64'd0,  1'b0, cltrt_pkg::ST_OK},
        '{cltrt_pkg::CMD_TERM_OF,  64'd10,  64'd0,   64'd0,  1'b0, cltrt_pkg::ST_OK},
        '{cltrt_pkg::CMD_TRUNCATE, 64'd12,  64'd0,   64'd0,  1'b0, cltrt_pkg::ST_OK},
        '{cltrt_pkg::CMD_SNAPSHOT, 64'd11,  64'd0,   64'd0,  1'b0, cltrt_pkg::ST_OK},
        '{cltrt_pkg::CMD_RESTORE,  IDX_MAX, IDX_MAX, 64'd0,  1'b1, cltrt_pkg::ST_OK},
        '{cltrt_pkg::CMD_APPEND,   64'd0,   64'd7,   64'd0,  1'b1, cltrt_pkg::ST_INVALID},
        '{cltrt_pkg::CMD_RESTORE,  64'd100, 64'd1,   64'd0,  1'b1, cltrt_pkg::ST_OK}
    };

    logic [31:0] trail_steps[5] = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd3, 32'd0};

    initial begin
        for (int i = 0; i < RUN_SLOTS; i++) begin
            run_li[i] = '0;
            run_tm[i] = '0;
        end
        ring_front = 0;
        run_count = 0;
        log_offset = '0;
        snap_idx = '0;
        snap_tm = '0;
        trailing = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed_rows[i])
            send_word(directed_rows[i].cmd, directed_rows[i].idx, directed_rows[i].trm,
                      directed_rows[i].sidx, directed_rows[i].typed, directed_rows[i].st);
        drain();
        for (int ph = 0; ph < 5; ph++) begin
            if (ph == 4) write_trailing($urandom_range(0, 20));
            else write_trailing(trail_steps[ph]);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                send_random();
                // hold off until the block has answered everything
                if (n == PHASE_WORDS / 2) drain();
            end
            drain();
        end
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
